// File: src/fba_pkg.sv
// Shared constants, command and status codes and result type of the frame bitmap allocator.
package fba_pkg;

	localparam int NUM_FRAMES_DEF = 4096;
	localparam int FT_W           = 13;
	localparam int IDX_W          = 12;
	localparam int ST_W           = 2;
	localparam int KIB_W          = 15;
	localparam int CMD_W          = 3;
	localparam int ADDR_W         = 32;
	localparam int WORD_BITS      = 32;
	localparam int BIT_W          = 5;
	localparam int WN_W           = FT_W - BIT_W;
	localparam int FRAME_SHIFT    = 12;
	localparam int FRAME_HI_W     = ADDR_W - FRAME_SHIFT;
	localparam int FT_MAX         = 8191;

	localparam logic [FT_W-1:0] FT_RESET = 13'd4096;

	localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TEST  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RUN   = 3'd4;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0] frame_index;
		logic [ST_W-1:0]  status;
		logic             is_used;
		logic [KIB_W-1:0] used_kib;
	} res_t;

endpackage

// File: src/fba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/fba_core.sv
// Command sequencer: read-modify-write of the bitmap memory, word scan and run scan.
module fba_core #(
	parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fba_pkg::CMD_W-1:0]   command,
	input  logic [fba_pkg::ADDR_W-1:0]  phys_address,
	input  logic [fba_pkg::FT_W-1:0]    run_length,
	input  logic [fba_pkg::FT_W-1:0]    total,
	output logic                        res_valid,
	input  logic                        res_ready,
	output fba_pkg::res_t               res
);
	import fba_pkg::*;

	// only frames below the largest frame total are reachable
	localparam int CAP   = (NUM_FRAMES > FT_MAX) ? FT_MAX : NUM_FRAMES;
	localparam int WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_RUN  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]           state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [FT_W-1:0]      frame_q;
	logic [FT_W-1:0]      want_q;
	logic [FT_W-1:0]      total_q;
	logic [WN_W-1:0]      wrd_q;
	logic [FT_W-1:0]      run_q;
	logic [WORD_BITS-1:0] word_q;
	logic [AW-1:0]        clr_q;
	logic [FT_W-1:0]      used_q;
	logic [IDX_W-1:0]     idx_q;
	logic [ST_W-1:0]      st_q;
	logic                 bit_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [WORD_BITS-1:0]  mem_wdata;
	logic [WORD_BITS-1:0]  rdata;

	logic [FRAME_HI_W-1:0] frame_in;
	logic [BIT_W-1:0]      zb;
	logic                  rbit;
	logic [FT_W-1:0]       f_nx;
	logic [FT_W-1:0]       run_n;
	logic [FT_W-1:0]       alloc_idx;
	logic [FT_W-1:0]       run_idx;
	logic                  wbit;

	fba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(AW'(wrd_q)),
		.rdata(rdata)
	);

	assign frame_in = phys_address[ADDR_W-1:FRAME_SHIFT];
	assign rbit     = rdata[frame_q[BIT_W-1:0]];
	assign wbit     = word_q[frame_q[BIT_W-1:0]];
	assign f_nx     = frame_q + FT_W'(1);
	assign run_n    = wbit ? '0 : (run_q + FT_W'(1));
	assign run_idx  = f_nx - want_q;
	assign alloc_idx = {wrd_q, zb};

	// lowest free bit of the word just read
	always_comb begin
		zb = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!rdata[b]) begin
				zb = BIT_W'(b);
			end
		end
	end

	// memory write port: clearing pass or write-back of a modified word
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(wrd_q);
		mem_wdata = rdata;
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (state_q == S_EVAL) begin
			unique case (cmd_q)
				CMD_SET: begin
					mem_we    = !rbit;
					mem_wdata = rdata | (WORD_BITS'(1) << frame_q[BIT_W-1:0]);
				end
				CMD_CLEAR: begin
					mem_we    = rbit;
					mem_wdata = rdata & ~(WORD_BITS'(1) << frame_q[BIT_W-1:0]);
				end
				CMD_ALLOC: begin
					mem_we    = (rdata != '1);
					mem_wdata = rdata | (WORD_BITS'(1) << zb);
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res.frame_index = idx_q;
	assign res.status      = st_q;
	assign res.is_used     = bit_q;
	assign res.used_kib    = {used_q, 2'b00};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			used_q  <= '0;
			cmd_q   <= CMD_SET;
			frame_q <= '0;
			want_q  <= '0;
			total_q <= '0;
			wrd_q   <= '0;
			run_q   <= '0;
			word_q  <= '0;
			idx_q   <= '0;
			st_q    <= ST_OK;
			bit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						want_q  <= run_length;
						total_q <= total;
						frame_q <= '0;
						wrd_q   <= '0;
						run_q   <= '0;
						idx_q   <= '0;
						st_q    <= ST_OK;
						bit_q   <= 1'b0;
						state_q <= S_FIN;
						unique case (command)
							CMD_SET, CMD_CLEAR, CMD_TEST: begin
								if (frame_in >= FRAME_HI_W'(total)) begin
									st_q <= ST_RANGE;
								end else begin
									frame_q <= frame_in[FT_W-1:0];
									wrd_q   <= frame_in[FT_W-1:BIT_W];
									state_q <= S_RD;
								end
							end
							CMD_ALLOC: begin
								if (total[FT_W-1:BIT_W] == '0) begin
									st_q <= ST_NOFREE;
								end else begin
									state_q <= S_RD;
								end
							end
							CMD_RUN: begin
								if (total == '0) begin
									st_q <= ST_NOFREE;
								end else if (run_length != '0) begin
									state_q <= S_RD;
								end
							end
							default: begin
								st_q <= ST_OK;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_FIN;
					unique case (cmd_q)
						CMD_SET: begin
							if (!rbit) begin
								used_q <= used_q + FT_W'(1);
							end
						end
						CMD_CLEAR: begin
							if (rbit) begin
								used_q <= used_q - FT_W'(1);
							end
						end
						CMD_TEST: begin
							bit_q <= rbit;
						end
						CMD_ALLOC: begin
							if (rdata != '1) begin
								idx_q  <= alloc_idx[IDX_W-1:0];
								used_q <= used_q + FT_W'(1);
							end else if ((wrd_q + WN_W'(1)) == total_q[FT_W-1:BIT_W]) begin
								st_q <= ST_NOFREE;
							end else begin
								wrd_q   <= wrd_q + WN_W'(1);
								state_q <= S_RD;
							end
						end
						CMD_RUN: begin
							word_q  <= rdata;
							state_q <= S_RUN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_RUN: begin
					// one frame per cycle, fetch the next word at a word boundary
					if (run_n >= want_q) begin
						idx_q   <= run_idx[IDX_W-1:0];
						state_q <= S_FIN;
					end else if (f_nx == total_q) begin
						st_q    <= ST_NOFREE;
						state_q <= S_FIN;
					end else begin
						frame_q <= f_nx;
						run_q   <= run_n;
						if (frame_q[BIT_W-1:0] == '1) begin
							wrd_q   <= wrd_q + WN_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/frame_bitmap_allocator.sv
// Top level of the frame bitmap allocator: configuration register, sequencer and result register.
// The bitmap lives in one RAM of 32-bit words, one bit per 4 KiB frame. After reset a clearing
// pass writes every word to zero, one word per cycle, and no transaction is taken until it
// ends; frame_total writes are taken at any time. Set, clear and test read the addressed word
// and evaluate it; set and clear write it back when the bit changes. Allocate reads and evaluates
// one bitmap word after another until it finds a free bit. Find-run walks the frames one per
// cycle and pauses to read and evaluate each 32-bit word it fetches. One transaction is in
// flight at a time; a finished result waits in the output register while the next transaction
// is accepted and worked on.
module frame_bitmap_allocator #(
	parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fba_pkg::FT_W-1:0]    cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fba_pkg::CMD_W-1:0]   command,
	input  logic [fba_pkg::ADDR_W-1:0]  phys_address,
	input  logic [fba_pkg::FT_W-1:0]    run_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fba_pkg::IDX_W-1:0]   frame_index,
	output logic [fba_pkg::ST_W-1:0]    status,
	output logic                        is_used,
	output logic [fba_pkg::KIB_W-1:0]   used_kib
);
	import fba_pkg::*;

	localparam int CAP = (NUM_FRAMES > FT_MAX) ? FT_MAX : NUM_FRAMES;
	localparam logic [FT_W-1:0] CAP_FT = FT_W'(CAP);

	logic [FT_W-1:0] ft_q;
	logic [FT_W-1:0] eff_total;
	logic            out_valid_q;
	res_t            out_q;
	res_t            res;
	logic            res_valid;
	logic            res_ready;

	// frame total register; its value is clamped to the bitmap size where it is used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q <= FT_RESET;
		end else if (cfg_we) begin
			ft_q <= cfg_wdata;
		end
	end

	assign eff_total = (ft_q > CAP_FT) ? CAP_FT : ft_q;

	fba_core #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.phys_address(phys_address),
		.run_length  (run_length),
		.total       (eff_total),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// result register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_index = out_q.frame_index;
	assign status      = out_q.status;
	assign is_used     = out_q.is_used;
	assign used_kib    = out_q.used_kib;

endmodule
